/* hw/rtl/efpa_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// efpa_pkg: shared types and constants of the encoder frame parser
// Frame bytes, position/angle widths and the frame record passed to the top.
// ----------------------------------------------------------------------------
package efpa_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned PosW   = 17;
  localparam int unsigned AngleW = 25;

  localparam logic [ByteW-1:0] HdrFirst  = 8'hA5;
  localparam logic [ByteW-1:0] HdrSecond = 8'h5A;

  // 2^17 - 1 counts per revolution; half scale splits positive and negative
  localparam logic [PosW-1:0] FullScale = 17'h1FFFF;
  localparam logic [PosW-1:0] HalfScale = 17'h10000;

  typedef logic [PosW-1:0]          pos_t;
  typedef logic signed [AngleW-1:0] angle_t;

  typedef struct packed {
    logic valid;     // frame completed by this transaction
    pos_t position;
    logic check_ok;
  } frame_t;

endpackage
`default_nettype wire

/* hw/rtl/efpa_parser.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// efpa_parser: byte-level frame state machine
// Hunts for the header pair, collects position bytes and checks the XOR byte.
// ----------------------------------------------------------------------------
module efpa_parser (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      byte_fire,
  input  wire logic [efpa_pkg::ByteW-1:0] rx_byte,
  output efpa_pkg::frame_t               frame,
  output logic                           at_check
);
  import efpa_pkg::*;

  localparam logic [2:0] PhHunt  = 3'd0;
  localparam logic [2:0] PhHdr2  = 3'd1;
  localparam logic [2:0] PhData1 = 3'd2;
  localparam logic [2:0] PhData2 = 3'd3;
  localparam logic [2:0] PhData3 = 3'd4;
  localparam logic [2:0] PhCheck = 3'd5;

  logic [2:0]       phase_r, phase_nxt;
  logic [ByteW-1:0] xor_r, xor_nxt;
  pos_t             shift_r, shift_nxt;

  always_comb begin
    phase_nxt = phase_r;
    xor_nxt   = xor_r;
    shift_nxt = shift_r;
    if (byte_fire) begin
      case (phase_r)
        PhHdr2: begin
          if (rx_byte == HdrSecond) begin
            xor_nxt   = HdrFirst ^ HdrSecond;
            shift_nxt = '0;
            phase_nxt = PhData1;
          end else if (rx_byte != HdrFirst) begin
            phase_nxt = PhHunt;
          end
        end
        PhData1: begin
          xor_nxt   = xor_r ^ rx_byte;
          shift_nxt = {{(PosW-1){1'b0}}, rx_byte[0]};
          phase_nxt = PhData2;
        end
        PhData2, PhData3: begin
          xor_nxt   = xor_r ^ rx_byte;
          shift_nxt = {shift_r[PosW-ByteW-1:0], rx_byte};
          phase_nxt = phase_r + 3'd1;
        end
        PhCheck: begin
          xor_nxt   = '0;
          phase_nxt = PhHunt;
        end
        default: begin
          // hunting, unused codes included
          phase_nxt = (rx_byte == HdrFirst) ? PhHdr2 : PhHunt;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PhHunt;
      xor_r   <= '0;
      shift_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      xor_r   <= xor_nxt;
      shift_r <= shift_nxt;
    end
  end

  assign at_check       = (phase_r == PhCheck);
  assign frame.valid    = byte_fire && at_check;
  assign frame.position = shift_r;
  assign frame.check_ok = (rx_byte == xor_r);

endmodule
`default_nettype wire

/* hw/rtl/efpa_angle.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// efpa_angle: position to signed Q9.16 degrees
// angle = num*360*2^16 / (2^17-1), truncated toward zero, no divider needed.
// ----------------------------------------------------------------------------
module efpa_angle (
  input  wire efpa_pkg::pos_t position,
  output efpa_pkg::angle_t    angle
);
  import efpa_pkg::*;

  logic             neg;
  pos_t             mag;
  logic [24:0]      prod;   // mag*360 < 2^25
  logic [7:0]       hi;
  logic [PosW:0]    sum;
  logic             wrap;
  logic [7:0]       quo;
  pos_t             rem;
  logic [23:0]      q;

  always_comb begin
    if (position < HalfScale) begin
      neg = 1'b0;
      mag = position;
    end else begin
      neg = 1'b1;
      mag = FullScale - position;
    end
    // 360 = 256 + 64 + 32 + 8
    prod = {mag, 8'b0} + {2'b0, mag, 6'b0} + {3'b0, mag, 5'b0} + {5'b0, mag, 3'b0};
    // prod = hi*2^17 + lo = hi*D + (hi + lo) with D = 2^17-1
    hi   = prod[24:17];
    sum  = {1'b0, prod[16:0]} + {10'b0, hi};
    wrap = (sum >= {1'b0, FullScale});
    quo  = hi + {7'b0, wrap};
    rem  = wrap ? PosW'(sum - {1'b0, FullScale}) : sum[PosW-1:0];
    // floor(rem*2^16/D) equals rem>>1 for rem < D
    q    = {quo, rem[PosW-1:1]};
  end

  assign angle = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});

endmodule
`default_nettype wire

/* hw/rtl/encoder_frame_parser_angle.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// encoder_frame_parser_angle: serial encoder frame parser with angle output
// Input channel: one byte per transaction (in_valid / in_stall, in_rx_byte).
// Frame: A5 5A d1 d2 d3 chk, chk = XOR of the five bytes before it; a
// repeated A5 before 5A is tolerated. Position = {d1[0], d2, d3}.
// Result channel: one transaction per completed frame carrying out_position,
// out_angle_q16 (signed degrees, Q9.16, truncated toward zero; 0 on a bad
// check) and out_check_ok.
// Latency: the result is valid the cycle after the check byte is taken.
// Throughput: one byte per cycle while in_stall is low; the parser state machine and the angle
// logic sit between the parser registers and the result register.
// Stall: a stalled result holds in the output register; the input keeps
// taking header and data bytes and stalls only on a check byte while the
// output register is full and stalled.
// Reset (rst_n low, synchronous): parser hunts for the header, output empty.
// ----------------------------------------------------------------------------
module encoder_frame_parser_angle (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [efpa_pkg::ByteW-1:0] in_rx_byte,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [efpa_pkg::PosW-1:0]       out_position,
  output logic signed [efpa_pkg::AngleW-1:0] out_angle_q16,
  output logic                            out_check_ok
);
  import efpa_pkg::*;

  frame_t frame;
  logic   at_check;
  angle_t angle;

  logic   out_valid_r;
  pos_t   pos_r;
  angle_t angle_r;
  logic   ok_r;

  assign in_stall = at_check && out_valid_r && out_stall;

  efpa_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_fire (in_valid && !in_stall),
    .rx_byte   (in_rx_byte),
    .frame     (frame),
    .at_check  (at_check)
  );

  efpa_angle u_angle (
    .position (frame.position),
    .angle    (angle)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (frame.valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame.valid) begin
      pos_r   <= frame.position;
      angle_r <= frame.check_ok ? angle : '0;
      ok_r    <= frame.check_ok;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_position  = pos_r;
  assign out_angle_q16 = angle_r;
  assign out_check_ok  = ok_r;

endmodule
`default_nettype wire

/* sim/encoder_frame_parser_angle_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_frame_parser_angle_test: self-checking bench for the frame parser
// Bytes are fed from a queue through the valid/stall input channel. Each
// accepted byte runs through a local parser model that predicts the
// position, Q9.16 angle and check flag of every completed frame. The result
// channel is compared field by field against those predictions. Stimulus is
// a few directed frames followed by random frames, bad checks, repeated
// headers, broken headers and noise, under three idle/stall profiles.
// ----------------------------------------------------------------------------
module encoder_frame_parser_angle_test;
  import efpa_pkg::*;

  localparam int unsigned StallLimit = 4000;
  localparam int unsigned BatchBytes = 475;
  localparam longint      Degrees    = 360;
  localparam longint      FracOne    = 65536;

  typedef enum logic [2:0] {
    PhHunt  = 3'd0,
    PhHdr2  = 3'd1,
    PhData1 = 3'd2,
    PhData2 = 3'd3,
    PhData3 = 3'd4,
    PhCheck = 3'd5
  } parse_phase_t;

  typedef struct packed {
    pos_t   position;
    angle_t angle;
    logic   check_ok;
  } reading_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [ByteW-1:0]  in_rx_byte = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [PosW-1:0]   out_position;
  logic signed [AngleW-1:0] out_angle_q16;
  logic              out_check_ok;

  logic [ByteW-1:0]  byte_queue[$];
  reading_t          readings_due[$];
  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;
  int                errors = 0;
  int unsigned       quiet_cycles = 0;
  bit                in_taken = 1'b0;

  // parser model state
  parse_phase_t      model_phase = PhHunt;
  logic [ByteW-1:0]  model_xor = '0;
  pos_t              model_pos = '0;

  encoder_frame_parser_angle u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_rx_byte   (in_rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_position (out_position),
    .out_angle_q16(out_angle_q16),
    .out_check_ok (out_check_ok)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic angle_t angle_of_position(pos_t p);
    longint num;
    if (p < HalfScale) num = longint'(p);
    else num = longint'(p) - longint'(FullScale);
    // longint division truncates toward zero
    return angle_t'((num * Degrees * FracOne) / longint'(FullScale));
  endfunction

  function automatic void parse_byte(logic [ByteW-1:0] b);
    reading_t r;
    case (model_phase)
      PhHdr2: begin
        if (b == HdrSecond) begin
          model_xor   = HdrFirst ^ HdrSecond;
          model_pos   = '0;
          model_phase = PhData1;
        end else if (b != HdrFirst) begin
          model_phase = PhHunt;
        end
      end
      PhData1: begin
        model_xor   = model_xor ^ b;
        model_pos   = pos_t'(b[0]);
        model_phase = PhData2;
      end
      PhData2, PhData3: begin
        model_xor   = model_xor ^ b;
        model_pos   = {model_pos[PosW-9:0], b};
        model_phase = (model_phase == PhData2) ? PhData3 : PhCheck;
      end
      PhCheck: begin
        r.position  = model_pos;
        r.check_ok  = (b == model_xor);
        r.angle     = r.check_ok ? angle_of_position(model_pos) : '0;
        readings_due.push_back(r);
        model_phase = PhHunt;
        model_xor   = '0;
      end
      default: begin
        model_phase = (b == HdrFirst) ? PhHdr2 : PhHunt;
      end
    endcase
  endfunction

  function automatic pos_t pick_position();
    case ($urandom_range(9))
      0: return '0;
      1: return pos_t'(65535);
      2: return HalfScale;
      3: return FullScale;
      4: return pos_t'(1);
      5: return pos_t'(131070);
      default: return pos_t'($urandom_range(131071));
    endcase
  endfunction

  // queue one frame; extra_hdr repeats the first header byte
  function automatic void push_frame(pos_t p, int extra_hdr, bit bad_check);
    logic [ByteW-1:0] d1, d2, d3, chk;
    d1  = {7'($urandom), p[16]};
    d2  = p[15:8];
    d3  = p[7:0];
    chk = HdrFirst ^ HdrSecond ^ d1 ^ d2 ^ d3;
    if (bad_check) chk = chk ^ 8'($urandom_range(255, 1));
    for (int i = 0; i <= extra_hdr; i++) byte_queue.push_back(HdrFirst);
    byte_queue.push_back(HdrSecond);
    byte_queue.push_back(d1);
    byte_queue.push_back(d2);
    byte_queue.push_back(d3);
    byte_queue.push_back(chk);
  endfunction

  task automatic add_random_traffic(int unsigned target);
    int unsigned count;
    int unsigned n;
    int          pick;
    logic [ByteW-1:0] b;
    count = 0;
    while (count < target) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        push_frame(pick_position(), 0, 1'b0);
        count += 6;
      end else if (pick < 72) begin
        push_frame(pick_position(), 0, 1'b1);
        count += 6;
      end else if (pick < 80) begin
        push_frame(pick_position(), $urandom_range(3, 1), $urandom_range(3) == 0);
        count += 8;
      end else if (pick < 88) begin
        // header start followed by a byte that aborts it
        do b = 8'($urandom); while (b == HdrSecond || b == HdrFirst);
        byte_queue.push_back(HdrFirst);
        byte_queue.push_back(b);
        count += 2;
      end else begin
        n = $urandom_range(4, 1);
        repeat (n) byte_queue.push_back(8'($urandom));
        count += n;
      end
    end
  endtask

  task automatic wait_input_drained();
    while (byte_queue.size() != 0 || in_valid) @(posedge clk);
  endtask

  // sample at the rising edge: input acceptance, model update, result check
  always @(posedge clk) begin
    reading_t e;
    in_taken = rst_n && in_valid && !in_stall;
    if (in_taken) parse_byte(in_rx_byte);
    if (rst_n && out_valid && !out_stall) begin
      if (readings_due.size() == 0) begin
        $display("%0t: unexpected result pos=%0d angle=%0d ok=%0b", $time,
                 out_position, out_angle_q16, out_check_ok);
        errors++;
      end else begin
        e = readings_due.pop_front();
        if (out_position !== e.position) begin
          $display("%0t: position expected %0d actual %0d", $time, e.position,
                   out_position);
          errors++;
        end
        if (out_angle_q16 !== e.angle) begin
          $display("%0t: angle_q16 expected %0d actual %0d", $time, e.angle,
                   out_angle_q16);
          errors++;
        end
        if (out_check_ok !== e.check_ok) begin
          $display("%0t: check_ok expected %0b actual %0b", $time, e.check_ok,
                   out_check_ok);
          errors++;
        end
      end
    end
    if (in_taken || (rst_n && out_valid && !out_stall)) quiet_cycles = 0;
    else if (rst_n) quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
      $display("simulation failed");
      $finish;
    end
  end

  // drive at the falling edge
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid   <= 1'b1;
        in_rx_byte <= byte_queue.pop_front();
      end else begin
        in_valid   <= 1'b0;
        in_rx_byte <= 8'($urandom);
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: zero position, repeated header at full scale, aborted header,
    // bad check at half scale, largest positive position
    send_idle_pct = 21;
    recv_idle_pct = 75;
    push_frame('0, 0, 1'b0);
    push_frame(FullScale, 1, 1'b0);
    byte_queue.push_back(HdrFirst);
    byte_queue.push_back(8'h13);
    push_frame(HalfScale, 0, 1'b1);
    push_frame(pos_t'(65535), 0, 1'b0);
    add_random_traffic(BatchBytes);
    wait_input_drained();

    send_idle_pct = 75;
    recv_idle_pct = 21;
    add_random_traffic(BatchBytes);
    wait_input_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random_traffic(BatchBytes);
    wait_input_drained();

    while (readings_due.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
